>>> sv/gmv_pkg.sv
// Package for the GF(2) matrix-vector product unit: types and constants.
`timescale 1ns / 1ps

package gmv_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 4;
    localparam int VEC_BITS  = NUM_WORDS * WORD_BITS;
    localparam int GRP_W     = $clog2(NUM_WORDS);
    localparam int COL_W     = $clog2(VEC_BITS);
    localparam int BIT_W     = $clog2(WORD_BITS);

    localparam logic [1:0] OP_LOAD_KEY = 2'd0;
    localparam logic [1:0] OP_LOAD_VEC = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [GRP_W-1:0]     row_group;
        logic [COL_W-1:0]     column;
        logic [WORD_BITS-1:0] data;
    } t_in;

    typedef struct packed {
        logic [GRP_W-1:0]     word_index;
        logic [WORD_BITS-1:0] product_word;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic clear;
        logic xor_en;
    } t_acc_ctrl;

    typedef logic [NUM_WORDS-1:0][WORD_BITS-1:0] t_words;

endpackage

>>> sv/gf2_matrix_vector_product_unit.sv
// Top level of the GF(2) 256x256 matrix times 256-bit vector product unit.
`timescale 1ns / 1ps

// A transaction on the input carries op, row_group, column and data. Op 0 writes a
// 64-bit key word (bit b = matrix entry at row 64*row_group+b, column `column`),
// op 1 writes vector word row_group, op 2 evaluates the product and op 3 is ignored.
// Loads produce nothing. An evaluate clears the accumulator, then walks the
// 256 columns, one per cycle: the four key RAMs (one per row group) are read
// together at the column address and the 256-bit column is XORed into the
// accumulator when the matching vector bit is set. Once the drain state has
// passed the last RAM read into the accumulator, the four product words leave
// as four output transactions, word_index 0 to 3, the last marked. An evaluate
// thus keeps the input not ready through the column walk, the drain state and
// the emission of the four words (longer while the output stalls); the last
// product word may still be waiting at the output while the next transaction
// is taken.
// Reading key or vector words that were never written gives undefined bits.

module gf2_matrix_vector_product_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gmv_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gmv_pkg::t_out o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state                          r_state, n_state;
    logic [gmv_pkg::COL_W-1:0]       r_col, n_col;
    logic                            r_rd_valid, n_rd_valid;
    logic                            r_rd_bit, n_rd_bit;
    logic [gmv_pkg::GRP_W-1:0]       r_emit_idx, n_emit_idx;
    logic                            r_out_valid, n_out_valid;
    gmv_pkg::t_out                   r_out, n_out;

    logic [gmv_pkg::WORD_BITS-1:0]   r_vec [gmv_pkg::NUM_WORDS];

    logic                            in_accept;
    logic [gmv_pkg::COL_W-1:0]       ram_addr;
    gmv_pkg::t_words                 col_words;
    gmv_pkg::t_acc_ctrl              acc_ctrl;
    logic [gmv_pkg::WORD_BITS-1:0]   acc_word;
    logic                            vec_bit;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    // Key RAMs are written from the input while idle and swept by column while running.
    assign ram_addr = (r_state == S_RUN) ? r_col : i_in_data.column;

    for (genvar g = 0; g < gmv_pkg::NUM_WORDS; g++) begin : g_key
        gmv_ram #(
            .WIDTH(gmv_pkg::WORD_BITS),
            .DEPTH(gmv_pkg::VEC_BITS)
        ) u_key_ram (
            .i_clk   (i_clk),
            .i_we    (in_accept && (i_in_data.op == gmv_pkg::OP_LOAD_KEY)
                      && (i_in_data.row_group == gmv_pkg::GRP_W'(g))),
            .i_addr  (ram_addr),
            .i_wdata (i_in_data.data),
            .o_rdata (col_words[g])
        );
    end

    // Vector store: written on load, one bit picked per column.
    always_ff @(posedge i_clk) begin
        if (in_accept && (i_in_data.op == gmv_pkg::OP_LOAD_VEC)) begin
            r_vec[i_in_data.row_group] <= i_in_data.data;
        end
    end

    assign vec_bit = r_vec[r_col[gmv_pkg::COL_W-1:gmv_pkg::BIT_W]][r_col[gmv_pkg::BIT_W-1:0]];

    assign acc_ctrl.clear  = in_accept && (i_in_data.op == gmv_pkg::OP_EVAL);
    assign acc_ctrl.xor_en = r_rd_valid && r_rd_bit;

    gmv_acc u_acc (
        .i_clk  (i_clk),
        .i_ctrl (acc_ctrl),
        .i_col  (col_words),
        .i_sel  (r_emit_idx),
        .o_word (acc_word)
    );

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_rd_valid  = 1'b0;
        n_rd_bit    = 1'b0;
        n_emit_idx  = r_emit_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_data.op == gmv_pkg::OP_EVAL)) begin
                    n_state = S_RUN;
                    n_col   = '0;
                end
            end
            S_RUN: begin
                // read data and its vector bit are both registered and line up in the next cycle
                n_rd_valid = 1'b1;
                n_rd_bit   = vec_bit;
                n_col      = r_col + 1'b1;
                if (r_col == gmv_pkg::COL_W'(gmv_pkg::VEC_BITS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state    = S_EMIT;
                n_emit_idx = '0;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out.word_index       = r_emit_idx;
                    n_out.product_word     = acc_word;
                    n_out.last             =
                        (r_emit_idx == gmv_pkg::GRP_W'(gmv_pkg::NUM_WORDS - 1));
                    n_emit_idx             = r_emit_idx + 1'b1;
                    if (r_emit_idx == gmv_pkg::GRP_W'(gmv_pkg::NUM_WORDS - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_bit    <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_rd_valid  <= n_rd_valid;
            r_rd_bit    <= n_rd_bit;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/gmv_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module gmv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/gmv_acc.sv
// Shared XOR accumulator holding the product words.
`timescale 1ns / 1ps

module gmv_acc (
    input  logic                          i_clk,
    input  gmv_pkg::t_acc_ctrl            i_ctrl,
    input  gmv_pkg::t_words               i_col,
    input  logic [gmv_pkg::GRP_W-1:0]     i_sel,
    output logic [gmv_pkg::WORD_BITS-1:0] o_word
);

    gmv_pkg::t_words r_acc;
    gmv_pkg::t_words n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.xor_en) begin
            n_acc = r_acc ^ i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_word = r_acc[i_sel];

endmodule

>>> test/gmv_product_checker.sv
// Checker for the GF(2) matrix-vector product unit: shadow stores, product prediction, compare.
`timescale 1ns / 1ps

module gmv_product_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  gmv_pkg::t_in   i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  gmv_pkg::t_out  i_out_data,
    output int             o_mismatch_count,
    output int             o_words_due
);

    // Shadow copies of the key matrix (row group, column) and the vector words.
    logic [gmv_pkg::WORD_BITS-1:0] key_shadow [gmv_pkg::NUM_WORDS][gmv_pkg::VEC_BITS];
    logic [gmv_pkg::WORD_BITS-1:0] vec_shadow [gmv_pkg::NUM_WORDS];

    gmv_pkg::t_out product_words_due [$];
    int            mismatches = 0;

    // Sum over GF(2) of the key columns selected by the set vector bits.
    function automatic gmv_pkg::t_words mat_vec_product();
        gmv_pkg::t_words acc;
        acc = '0;
        for (int col = 0; col < gmv_pkg::VEC_BITS; col++) begin
            if (vec_shadow[col / gmv_pkg::WORD_BITS][col % gmv_pkg::WORD_BITS]) begin
                for (int g = 0; g < gmv_pkg::NUM_WORDS; g++) begin
                    acc[g] ^= key_shadow[g][col];
                end
            end
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        gmv_pkg::t_words prod;
        gmv_pkg::t_out   want;
        if (i_rst_n) begin
            // Output side first: a product word can never belong to an evaluate
            // accepted at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (product_words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%t: unexpected product word: got index %0d word %h last %b",
                                 $realtime, i_out_data.word_index, i_out_data.product_word,
                                 i_out_data.last);
                    end
                end else begin
                    want = product_words_due.pop_front();
                    if (i_out_data.word_index !== want.word_index ||
                        i_out_data.product_word !== want.product_word ||
                        i_out_data.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t: product word mismatch: expected %0d %h %b",
                                     $realtime, want.word_index, want.product_word,
                                     want.last);
                            $display("%t:                        got      %0d %h %b",
                                     $realtime, i_out_data.word_index,
                                     i_out_data.product_word, i_out_data.last);
                        end
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (i_in_data.op)
                    gmv_pkg::OP_LOAD_KEY: begin
                        key_shadow[i_in_data.row_group][i_in_data.column] = i_in_data.data;
                    end
                    gmv_pkg::OP_LOAD_VEC: begin
                        vec_shadow[i_in_data.row_group] = i_in_data.data;
                    end
                    gmv_pkg::OP_EVAL: begin
                        prod = mat_vec_product();
                        for (int g = 0; g < gmv_pkg::NUM_WORDS; g++) begin
                            want.word_index   = g[gmv_pkg::GRP_W-1:0];
                            want.product_word = prod[g];
                            want.last         = (g == gmv_pkg::NUM_WORDS - 1);
                            product_words_due.push_back(want);
                        end
                    end
                    default: ;  // unused opcode: no effect
                endcase
            end
        end
        o_mismatch_count <= mismatches;
        o_words_due      <= product_words_due.size();
    end

endmodule

>>> test/tb_gf2_matrix_vector_product_unit.sv
// Testbench top for the GF(2) matrix-vector product unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

// Stimulus first loads every key and vector word, so that no evaluate ever reads an
// unwritten store entry. A short directed run then covers zero and all-ones vectors,
// the corner columns and row groups, the unused opcode and repeated evaluates. The
// random run mixes key loads, vector loads and evaluates with shaped data (zero,
// all ones, one-hot, sparse, dense). Both channels idle at random, with one stretch
// of full throughput, and once the output is held off long enough for the unit to
// back up and stall its input. The checker beside the unit does the predicting.

module tb_gf2_matrix_vector_product_unit;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 420;
    localparam int IDLE_PCT       = 37;
    localparam int HOLD_CYCLES    = 1500;   // several evaluate walks' worth
    localparam int HOLD_AT        = 140;
    localparam int BUSY_FROM      = 260;    // no idling on either side in here
    localparam int BUSY_TO        = 340;
    localparam int DRAIN_CYCLES   = 300;    // one column walk plus output words
    localparam int WATCHDOG_LIMIT = 10000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    gmv_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_ready;
    gmv_pkg::t_out out_data;

    int mismatch_count;
    int words_due;

    // Flow-control knobs shared by the stimulus and the output side.
    bit idle_on;
    bit hold_req;

    gf2_matrix_vector_product_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    gmv_product_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_data       (out_data),
        .o_mismatch_count (mismatch_count),
        .o_words_due      (words_due)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [gmv_pkg::GRP_W-1:0] rand_grp();
        return gmv_pkg::GRP_W'($urandom_range(gmv_pkg::NUM_WORDS - 1));
    endfunction

    function automatic logic [gmv_pkg::COL_W-1:0] rand_col();
        return gmv_pkg::COL_W'($urandom_range(gmv_pkg::VEC_BITS - 1));
    endfunction

    // Data patterns that reach the corners of the GF(2) sum: empty, full, one-hot,
    // sparse and dense words.
    function automatic logic [gmv_pkg::WORD_BITS-1:0] shaped_word();
        logic [gmv_pkg::WORD_BITS-1:0] one_hot;
        one_hot = '0;
        one_hot[gmv_pkg::BIT_W'($urandom_range(gmv_pkg::WORD_BITS - 1))] = 1'b1;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one input transaction and return at the edge where it is taken. Random
    // idle cycles go in front, with valid low; once raised, valid and payload hold.
    task automatic offer(input logic [1:0] op, input logic [gmv_pkg::GRP_W-1:0] grp,
                         input logic [gmv_pkg::COL_W-1:0] col,
                         input logic [gmv_pkg::WORD_BITS-1:0] word);
        gmv_pkg::t_in item;
        item.op        = op;
        item.row_group = grp;
        item.column    = col;
        item.data      = word;
        if (idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // Output side: random stalls, plus a single long hold-off on request.
    initial begin
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
            end else begin
                out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: too long without a transaction on either channel ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_gf2_matrix_vector_product_unit NOT OK");
        $finish;
    end

    initial begin
        int counted;
        int pick;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        idle_on  <= 1'b1;
        hold_req <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill both stores completely before any evaluate.
        for (int g = 0; g < gmv_pkg::NUM_WORDS; g++) begin
            for (int c = 0; c < gmv_pkg::VEC_BITS; c++) begin
                offer(gmv_pkg::OP_LOAD_KEY, g[gmv_pkg::GRP_W-1:0], c[gmv_pkg::COL_W-1:0],
                      shaped_word());
            end
        end
        for (int w = 0; w < gmv_pkg::NUM_WORDS; w++) begin
            offer(gmv_pkg::OP_LOAD_VEC, w[gmv_pkg::GRP_W-1:0], rand_col(), shaped_word());
        end

        // Directed: zero vector gives a zero product.
        for (int w = 0; w < gmv_pkg::NUM_WORDS; w++) begin
            offer(gmv_pkg::OP_LOAD_VEC, w[gmv_pkg::GRP_W-1:0], '0, '0);
        end
        offer(gmv_pkg::OP_EVAL, '0, '0, '0);

        // Corner columns and row groups, with only the first and last vector bits set.
        offer(gmv_pkg::OP_LOAD_KEY, 2'd0, 8'd0,   '1);
        offer(gmv_pkg::OP_LOAD_KEY, 2'd3, 8'd255, '1);
        offer(gmv_pkg::OP_LOAD_KEY, 2'd1, 8'd128, 64'h8000_0000_0000_0001);
        offer(gmv_pkg::OP_LOAD_VEC, 2'd0, 8'd255, 64'h0000_0000_0000_0001);
        offer(gmv_pkg::OP_LOAD_VEC, 2'd3, 8'd0,   64'h8000_0000_0000_0000);
        offer(gmv_pkg::OP_EVAL, 2'd3, 8'd255, '1);

        // Unused opcode must leave everything alone; evaluate again to prove it.
        offer(OP_UNUSED, 2'd3, 8'd255, '1);
        offer(OP_UNUSED, 2'd0, 8'd0,   '0);
        offer(gmv_pkg::OP_EVAL, 2'd0, 8'd0, '0);

        // Bring in the middle column, then an all-ones vector, evaluated twice.
        offer(gmv_pkg::OP_LOAD_VEC, 2'd2, 8'd17, 64'h0000_0000_0000_0001);
        offer(gmv_pkg::OP_EVAL, 2'd1, 8'd64, 64'h5555_5555_5555_5555);
        for (int w = 0; w < gmv_pkg::NUM_WORDS; w++) begin
            offer(gmv_pkg::OP_LOAD_VEC, w[gmv_pkg::GRP_W-1:0], '1, '1);
        end
        offer(gmv_pkg::OP_EVAL, 2'd2, 8'd127, 64'hAAAA_AAAA_AAAA_AAAA);
        offer(gmv_pkg::OP_EVAL, 2'd1, 8'd1, '0);

        // Random run: mostly loads feeding evaluates, some unused-opcode noise.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted == BUSY_FROM) idle_on <= 1'b0;
            if (counted == BUSY_TO)   idle_on <= 1'b1;
            if (counted == HOLD_AT && !hold_req) begin
                // Output held off while evaluates keep coming: the unit backs up.
                hold_req <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    offer(gmv_pkg::OP_EVAL, rand_grp(), rand_col(), shaped_word());
                    offer(gmv_pkg::OP_LOAD_KEY, rand_grp(), rand_col(), shaped_word());
                end
                counted += 6;
            end
            pick = $urandom_range(99);
            if (pick < 4) begin
                offer(OP_UNUSED, rand_grp(), rand_col(), shaped_word());
            end else if (pick < 20) begin
                offer(gmv_pkg::OP_EVAL, rand_grp(), rand_col(), shaped_word());
                counted++;
            end else if (pick < 32) begin
                offer(gmv_pkg::OP_LOAD_VEC, rand_grp(), rand_col(), shaped_word());
                counted++;
            end else begin
                offer(gmv_pkg::OP_LOAD_KEY, rand_grp(), rand_col(), shaped_word());
                counted++;
            end
        end

        // Drain: the checker's count is registered, so it trails the last transaction.
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && words_due == 0) begin
            $display("tb_gf2_matrix_vector_product_unit OK");
        end else begin
            $display("tb_gf2_matrix_vector_product_unit NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/gmv_pkg.sv
sv/gmv_ram.sv
sv/gmv_acc.sv
sv/gf2_matrix_vector_product_unit.sv
test/gmv_product_checker.sv
test/tb_gf2_matrix_vector_product_unit.sv
